@@ rtl/v2dc_pkg.sv @@
// Shared types, constants and helper functions for the valid-region 2D convolution core.
// Used by every module under rtl/; it has no dependencies of its own.
`timescale 1ns / 1ps

package v2dc_pkg;

  // Geometry and arithmetic sizes.
  localparam int unsigned MAX_WIDTH_DEF = 1024;
  localparam int unsigned KERNEL        = 3;
  localparam int unsigned LINES         = KERNEL - 1;
  localparam int unsigned CHANNELS      = 3;
  localparam int unsigned PIX_W         = 8;
  localparam int unsigned PIXEL_W       = CHANNELS * PIX_W;
  localparam int unsigned COEF_W        = 16;
  localparam int unsigned PROD_W        = COEF_W + PIX_W;
  localparam int unsigned SUM_W         = 28;
  localparam int unsigned FRAC_W        = 12;
  localparam int unsigned GEOM_W        = 13;
  localparam int unsigned DIM_W         = 11;
  localparam int unsigned ROW_W         = 10;
  localparam int unsigned KSIZE_W       = 2;
  localparam int unsigned CFG_IDX_W     = 3;
  localparam int unsigned CFG_DATA_W    = 48;

  localparam logic [DIM_W-1:0]   DIM_RESET    = 11'd1024;
  localparam logic [DIM_W-1:0]   HEIGHT_LIMIT = 11'd1024;
  localparam logic [KSIZE_W-1:0] KSIZE_RESET  = 2'd3;
  localparam logic [PIX_W-1:0]   BYTE_MAX     = 8'd255;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 3'd0,
    CFG_IMAGE_HEIGHT = 3'd1,
    CFG_KERNEL_ROWS  = 3'd2,
    CFG_KERNEL_COLS  = 3'd3,
    CFG_COEF_TOP     = 3'd4,
    CFG_COEF_MID     = 3'd5,
    CFG_COEF_BOT     = 3'd6
  } cfg_idx_e;

  // A packed pixel holds red in the low byte.
  typedef logic [PIXEL_W-1:0]                 pixel_t;
  typedef pixel_t [KERNEL-1:0]                column_t;
  typedef pixel_t [KERNEL-1:0][KERNEL-1:0]    window_t;
  typedef logic [COEF_W-1:0]                  coef_t;
  typedef coef_t [KERNEL-1:0][KERNEL-1:0]     coef_grid_t;

  typedef struct packed {
    logic [PIX_W-1:0] blue_in;
    logic [PIX_W-1:0] green_in;
    logic [PIX_W-1:0] red_in;
  } in_item_t;

  typedef struct packed {
    logic                    frame_end;
    logic [PIX_W-1:0]        blue_byte;
    logic [PIX_W-1:0]        green_byte;
    logic [PIX_W-1:0]        red_byte;
    logic signed [SUM_W-1:0] blue_sum;
    logic signed [SUM_W-1:0] green_sum;
    logic signed [SUM_W-1:0] red_sum;
  } out_item_t;

  // Control that travels with a pixel down the pipeline.
  typedef struct packed {
    logic vld;
    logic produce;
    logic frame_end;
  } stage_ctl_t;

  // Status the arithmetic unit reports back to the stage ahead of it.
  typedef struct packed {
    logic ready;
    logic busy;
  } mac_status_t;

  // Picks kernel coefficient (m, n) from the three packed row registers.
  function automatic coef_t coef_pick(input logic [CFG_DATA_W-1:0] top,
                                      input logic [CFG_DATA_W-1:0] mid,
                                      input logic [CFG_DATA_W-1:0] bot,
                                      input logic [KSIZE_W-1:0]    m,
                                      input logic [KSIZE_W-1:0]    n);
    logic [CFG_DATA_W-1:0] row;
    coef_t                 res;
    unique case (m)
      2'd0:    row = top;
      2'd1:    row = mid;
      default: row = bot;
    endcase
    unique case (n)
      2'd0:    res = row[0*COEF_W +: COEF_W];
      2'd1:    res = row[1*COEF_W +: COEF_W];
      default: res = row[2*COEF_W +: COEF_W];
    endcase
    return res;
  endfunction

  // Truncates a Q.12 sum toward zero and clamps it to a byte.
  function automatic logic [PIX_W-1:0] to_byte(input logic signed [SUM_W-1:0] s);
    logic [PIX_W-1:0] res;
    if (s[SUM_W-1]) begin
      res = '0;
    end else if (|s[SUM_W-2:FRAC_W+PIX_W]) begin
      res = BYTE_MAX;
    end else begin
      res = s[FRAC_W+PIX_W-1:FRAC_W];
    end
    return res;
  endfunction

endpackage

@@ rtl/v2dc_line_buffer.sv @@
// Line store for the previous image rows, with a registered read port and write forwarding.
// Depends on v2dc_pkg.
`timescale 1ns / 1ps

module v2dc_line_buffer #(
  parameter int unsigned MAX_WIDTH = v2dc_pkg::MAX_WIDTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         load_i,
  input  logic [$clog2(MAX_WIDTH)-1:0] addr_i,
  input  v2dc_pkg::pixel_t             pix_i,
  output v2dc_pkg::column_t            col_o
);

  localparam int unsigned AW     = $clog2(MAX_WIDTH);
  localparam int unsigned LINE_W = v2dc_pkg::LINES * v2dc_pkg::PIXEL_W;

  // One word per column: the low slot is the previous row, the next slot the row before.
  logic [LINE_W-1:0]  mem_q [MAX_WIDTH];
  logic [LINE_W-1:0]  rd_q;
  logic [LINE_W-1:0]  wr_data;
  v2dc_pkg::pixel_t   pix_q;
  logic [AW-1:0]      addr_q;
  logic               wr_pend_q;
  logic               fwd;

  // The column word written back: rows age by one slot, the new pixel enters the low slot.
  assign wr_data = {rd_q[LINE_W-v2dc_pkg::PIXEL_W-1:0], pix_q};

  // A read in the cycle of a pending write to the same column takes the new word.
  assign fwd = wr_pend_q && (addr_q == addr_i);

  // The write lands in the cycle after the read, once the old rows are at hand.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_pend_q <= 1'b0;
    end else begin
      wr_pend_q <= load_i;
    end
  end

  // Memory array and read data register.
  always_ff @(posedge clk_i) begin
    if (wr_pend_q) begin
      mem_q[addr_q] <= wr_data;
    end
    if (load_i) begin
      rd_q   <= fwd ? wr_data : mem_q[addr_i];
      pix_q  <= pix_i;
      addr_q <= addr_i;
    end
  end

  // New window column, oldest row first and the current pixel last.
  always_comb begin
    col_o[v2dc_pkg::KERNEL-1] = pix_q;
    for (int s = 0; s < int'(v2dc_pkg::LINES); s++) begin
      col_o[int'(v2dc_pkg::KERNEL) - 2 - s] = rd_q[s*v2dc_pkg::PIXEL_W +: v2dc_pkg::PIXEL_W];
    end
  end

endmodule

@@ rtl/v2dc_window.sv @@
// Shifting pixel window: one new column enters on the right for every pixel.
// Depends on v2dc_pkg.
`timescale 1ns / 1ps

module v2dc_window (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                shift_i,
  input  v2dc_pkg::column_t   col_i,
  output v2dc_pkg::window_t   win_o
);

  v2dc_pkg::window_t win_q;
  v2dc_pkg::window_t win_d;

  // Every row moves one column left, and the new column fills the right edge.
  always_comb begin
    for (int i = 0; i < int'(v2dc_pkg::KERNEL); i++) begin
      for (int j = 0; j < int'(v2dc_pkg::KERNEL) - 1; j++) begin
        win_d[i][j] = win_q[i][j+1];
      end
      win_d[i][v2dc_pkg::KERNEL-1] = col_i[i];
    end
  end

  // The window starts out all zero after reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (shift_i) begin
      win_q <= win_d;
    end
  end

  assign win_o = win_q;

endmodule

@@ rtl/v2dc_mac.sv @@
// Multiply stage and sum stage for the three channels, ending in the output register.
// Depends on v2dc_pkg.
`timescale 1ns / 1ps

module v2dc_mac (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  v2dc_pkg::stage_ctl_t    ctl_i,
  input  v2dc_pkg::window_t       win_i,
  input  v2dc_pkg::coef_grid_t    coef_i,
  output v2dc_pkg::mac_status_t   status_o,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output v2dc_pkg::out_item_t     out_data_o
);

  localparam int unsigned CH = v2dc_pkg::CHANNELS;
  localparam int unsigned K  = v2dc_pkg::KERNEL;

  typedef logic signed [v2dc_pkg::PROD_W-1:0] prod_t;
  typedef logic signed [v2dc_pkg::SUM_W-1:0]  sum_t;

  prod_t               prod_d [CH][K][K];
  prod_t               prod_q [CH][K][K];
  sum_t                sum_d  [CH];
  logic                s3_vld_q;
  logic                s3_end_q;
  logic                out_vld_q;
  v2dc_pkg::out_item_t out_q;
  v2dc_pkg::out_item_t out_d;
  logic                s4_en;
  logic                s3_free;
  logic                take;

  // Handshake between the product stage and the output register.
  assign s4_en   = !out_vld_q || !out_stall_i;
  assign s3_free = !s3_vld_q || s4_en;
  assign take    = ctl_i.vld && ctl_i.produce && s3_free;

  assign status_o.ready = s3_free;
  assign status_o.busy  = s3_vld_q;

  // One signed coefficient times one unsigned sample per window tap and channel.
  always_comb begin
    for (int c = 0; c < int'(CH); c++) begin
      for (int i = 0; i < int'(K); i++) begin
        for (int j = 0; j < int'(K); j++) begin
          prod_d[c][i][j] = v2dc_pkg::PROD_W'($signed(coef_i[i][j]) *
                            $signed({1'b0, win_i[i][j][c*v2dc_pkg::PIX_W +: v2dc_pkg::PIX_W]}));
        end
      end
    end
  end

  // Sum of the registered products; inactive taps carry a zero coefficient.
  always_comb begin
    for (int c = 0; c < int'(CH); c++) begin
      sum_d[c] = '0;
      for (int i = 0; i < int'(K); i++) begin
        for (int j = 0; j < int'(K); j++) begin
          sum_d[c] = sum_d[c] + v2dc_pkg::SUM_W'(prod_q[c][i][j]);
        end
      end
    end
  end

  // Result transaction assembled from the sums.
  always_comb begin
    out_d.red_sum    = sum_d[0];
    out_d.green_sum  = sum_d[1];
    out_d.blue_sum   = sum_d[2];
    out_d.red_byte   = v2dc_pkg::to_byte(sum_d[0]);
    out_d.green_byte = v2dc_pkg::to_byte(sum_d[1]);
    out_d.blue_byte  = v2dc_pkg::to_byte(sum_d[2]);
    out_d.frame_end  = s3_end_q;
  end

  // Stage valid flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (s3_free) begin
        s3_vld_q <= take;
      end
      if (s4_en) begin
        out_vld_q <= s3_vld_q;
      end
    end
  end

  // Stage payloads.
  always_ff @(posedge clk_i) begin
    if (take) begin
      prod_q   <= prod_d;
      s3_end_q <= ctl_i.frame_end;
    end
    if (s4_en && s3_vld_q) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

@@ rtl/valid_2d_convolution_stream_core.sv @@
// Valid-region 2D convolution core: three channels, one shared kernel of up to 3x3 taps.
// A pixel passes the line store, window, product and output registers. Throughput: one pixel
// per cycle when the output is not stalled, set by the single read port of the line store and
// the one registered bank of 27 multipliers. Reset clears counters, pipeline valids, the window
// and the registers to their defaults; the line store is not cleared and needs no clearing pass.
// Depends on v2dc_pkg, v2dc_line_buffer, v2dc_window and v2dc_mac.
`timescale 1ns / 1ps

module valid_2d_convolution_stream_core #(
  parameter int unsigned MAX_WIDTH = v2dc_pkg::MAX_WIDTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  v2dc_pkg::in_item_t                  in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output v2dc_pkg::out_item_t                 out_data_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [v2dc_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [v2dc_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int unsigned AW = $clog2(MAX_WIDTH);
  localparam int unsigned GW = v2dc_pkg::GEOM_W;
  localparam int unsigned DW = v2dc_pkg::DIM_W;
  localparam int unsigned KW = v2dc_pkg::KSIZE_W;

  logic [DW-1:0]                    width_q;
  logic [DW-1:0]                    height_q;
  logic [KW-1:0]                    krows_q;
  logic [KW-1:0]                    kcols_q;
  logic [v2dc_pkg::CFG_DATA_W-1:0]  coef_top_q;
  logic [v2dc_pkg::CFG_DATA_W-1:0]  coef_mid_q;
  logic [v2dc_pkg::CFG_DATA_W-1:0]  coef_bot_q;

  logic [AW-1:0]                    col_q;
  logic [v2dc_pkg::ROW_W-1:0]       row_q;
  logic [GW-1:0]                    w_eff;
  logic [DW-1:0]                    h_eff;
  logic [KW-1:0]                    kh_eff;
  logic [KW-1:0]                    kw_eff;
  logic [GW-1:0]                    col_next;
  logic [DW-1:0]                    row_next;
  logic                             last_col;
  logic                             last_row;
  logic                             produce;

  logic                             in_fire;
  logic                             cfg_fire;
  v2dc_pkg::stage_ctl_t             s1_ctl_q;
  v2dc_pkg::stage_ctl_t             s2_ctl_q;
  logic                             s1_move;
  logic                             s1_free;
  logic                             s2_move;
  logic                             s2_free;
  v2dc_pkg::pixel_t                 in_pix;
  v2dc_pkg::column_t                new_col;
  v2dc_pkg::window_t                win;
  v2dc_pkg::coef_grid_t             coef_eff;
  v2dc_pkg::mac_status_t            mac_status;

  // Handshakes.
  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;
  assign in_fire     = in_valid_i && !in_stall_o;
  assign in_stall_o  = !s1_free;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q    <= v2dc_pkg::DIM_RESET;
      height_q   <= v2dc_pkg::DIM_RESET;
      krows_q    <= v2dc_pkg::KSIZE_RESET;
      kcols_q    <= v2dc_pkg::KSIZE_RESET;
      coef_top_q <= '0;
      coef_mid_q <= '0;
      coef_bot_q <= '0;
    end else if (cfg_fire) begin
      unique case (cfg_index_i)
        v2dc_pkg::CFG_IMAGE_WIDTH:  width_q    <= cfg_data_i[DW-1:0];
        v2dc_pkg::CFG_IMAGE_HEIGHT: height_q   <= cfg_data_i[DW-1:0];
        v2dc_pkg::CFG_KERNEL_ROWS:  krows_q    <= cfg_data_i[KW-1:0];
        v2dc_pkg::CFG_KERNEL_COLS:  kcols_q    <= cfg_data_i[KW-1:0];
        v2dc_pkg::CFG_COEF_TOP:     coef_top_q <= cfg_data_i;
        v2dc_pkg::CFG_COEF_MID:     coef_mid_q <= cfg_data_i;
        v2dc_pkg::CFG_COEF_BOT:     coef_bot_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Effective geometry: zero sizes act as one, oversize values are capped.
  always_comb begin
    priority if (width_q == '0) begin
      w_eff = GW'(1);
    end else if (GW'(width_q) > GW'(MAX_WIDTH)) begin
      w_eff = GW'(MAX_WIDTH);
    end else begin
      w_eff = GW'(width_q);
    end
    priority if (height_q == '0) begin
      h_eff = DW'(1);
    end else if (height_q > v2dc_pkg::HEIGHT_LIMIT) begin
      h_eff = v2dc_pkg::HEIGHT_LIMIT;
    end else begin
      h_eff = height_q;
    end
    kh_eff = (krows_q == '0) ? KW'(1) : krows_q;
    kw_eff = (kcols_q == '0) ? KW'(1) : kcols_q;
  end

  // Position of the incoming pixel and whether its window lies inside the image.
  assign col_next = GW'(col_q) + GW'(1);
  assign row_next = DW'(row_q) + DW'(1);
  assign last_col = col_next >= w_eff;
  assign last_row = row_next >= h_eff;
  assign produce  = (row_next >= DW'(kh_eff)) && (col_next >= GW'(kw_eff));

  // Raster counters advance on every accepted pixel.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_fire) begin
      if (last_col) begin
        col_q <= '0;
        row_q <= last_row ? '0 : row_next[v2dc_pkg::ROW_W-1:0];
      end else begin
        col_q <= col_next[AW-1:0];
      end
    end
  end

  // Kernel laid over the bottom-right corner of the window; unused taps are zero.
  always_comb begin
    int row_off;
    int col_off;
    row_off = int'(v2dc_pkg::KERNEL) - int'(kh_eff);
    col_off = int'(v2dc_pkg::KERNEL) - int'(kw_eff);
    for (int i = 0; i < int'(v2dc_pkg::KERNEL); i++) begin
      for (int j = 0; j < int'(v2dc_pkg::KERNEL); j++) begin
        if (i >= row_off && j >= col_off) begin
          coef_eff[i][j] = v2dc_pkg::coef_pick(coef_top_q, coef_mid_q, coef_bot_q,
                                               KW'(i - row_off), KW'(j - col_off));
        end else begin
          coef_eff[i][j] = '0;
        end
      end
    end
  end

  // Pipeline flow: each stage moves when the one after it has room.
  assign s2_move = s2_ctl_q.vld && (!s2_ctl_q.produce || mac_status.ready);
  assign s2_free = !s2_ctl_q.vld || s2_move;
  assign s1_move = s1_ctl_q.vld && s2_free;
  assign s1_free = !s1_ctl_q.vld || s1_move;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_ctl_q <= '0;
      s2_ctl_q <= '0;
    end else begin
      if (s1_free) begin
        s1_ctl_q.vld       <= in_fire;
        s1_ctl_q.produce   <= produce;
        s1_ctl_q.frame_end <= last_col && last_row;
      end
      if (s1_move) begin
        s2_ctl_q <= s1_ctl_q;
      end else if (s2_move) begin
        s2_ctl_q.vld <= 1'b0;
      end
    end
  end

  assign in_pix = {in_data_i.blue_in, in_data_i.green_in, in_data_i.red_in};

  v2dc_line_buffer #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_line_buffer (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (in_fire),
    .addr_i (col_q),
    .pix_i  (in_pix),
    .col_o  (new_col)
  );

  v2dc_window u_window (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .shift_i (s1_move),
    .col_i   (new_col),
    .win_o   (win)
  );

  v2dc_mac u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (s2_ctl_q),
    .win_i       (win),
    .coef_i      (coef_eff),
    .status_o    (mac_status),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // The last pixel of a frame leaves both counters at zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && last_col && last_row |=> (col_q == '0) && (row_q == '0))
    else $error("raster counters did not wrap at the end of the frame");

  // Back-pressure reaches the input only when every stage is full.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_ctl_q.vld |-> !in_stall_o)
    else $error("input stalled while the first stage is empty");

  // A full pipeline behind a stalled result must stall the input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_ctl_q.vld && s2_ctl_q.vld && s2_ctl_q.produce && mac_status.busy &&
    out_valid_o && out_stall_i |-> in_stall_o)
    else $error("input accepted while the pipeline is full and stalled");

  // A pixel leaving the first stage shows up in the window stage next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_move |=> s2_ctl_q.vld)
    else $error("pixel lost between the line store and the window");

endmodule
